// ----- rtl/pcs_pkg.sv -----
// Shared types, codes and letter/cell helper functions for the Playfair stream block.
// No dependencies; imported by pcs_ctrl, pcs_datapath and playfair_cipher_stream.
`default_nettype none

package pcs_pkg;

  // Letter index 0..25, or a cell 0..24 of the square
  typedef logic [4:0] idx_t;
  // Row or column 0..4
  typedef logic [2:0] rc_t;

  localparam idx_t I_IDX    = 5'd8;
  localparam idx_t J_IDX    = 5'd9;
  localparam idx_t LAST_IDX = 5'd25;
  localparam idx_t NONE_IDX = 5'd26;
  localparam idx_t CELLS    = 5'd25;

  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_Z  = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_X  = 8'h58;

  localparam rc_t STEP_ENC = 3'd1;
  localparam rc_t STEP_DEC = 3'd4;

  typedef enum logic [2:0] {
    CMD_KEY_CHAR  = 3'd0,
    CMD_KEY_END   = 3'd1,
    CMD_TEXT_CHAR = 3'd2,
    CMD_TEXT_END  = 3'd3,
    CMD_CLEAR_KEY = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_CELL,
    ST_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic key_char;
    logic key_end;
    logic clear;
    logic text_char;
    logic text_end;
    logic fill_step;
    logic look;
    logic sq_read;
    logic load;
  } pcs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pair_go;
    logic fill_last;
    logic out_busy;
  } pcs_stat_t;

  function automatic logic is_upper(logic [7:0] ch);
    return (ch >= CH_A) && (ch <= CH_Z);
  endfunction

  // Index of an uppercase byte with J read as I; 0 for anything else
  function automatic idx_t upper_idx(logic [7:0] ch);
    logic [7:0] d;
    d = ch - CH_A;
    if (!is_upper(ch)) return '0;
    if (d[4:0] == J_IDX) return I_IDX;
    return d[4:0];
  endfunction

  // Index of a letter of either case with J read as I; NONE_IDX for a non-letter
  function automatic idx_t letter_idx(logic [7:0] ch);
    logic [7:0] d;
    d = '0;
    if (is_upper(ch)) begin
      d = ch - CH_A;
    end else if ((ch >= CH_LA) && (ch <= CH_LZ)) begin
      d = ch - CH_LA;
    end else begin
      return NONE_IDX;
    end
    if (d[4:0] == J_IDX) return I_IDX;
    return d[4:0];
  endfunction

  function automatic rc_t cell_row(idx_t p);
    if (p >= 5'd20) return 3'd4;
    if (p >= 5'd15) return 3'd3;
    if (p >= 5'd10) return 3'd2;
    if (p >= 5'd5)  return 3'd1;
    return 3'd0;
  endfunction

  function automatic rc_t cell_col(idx_t p);
    logic [4:0] r5;
    logic [4:0] c5;
    r5 = {2'b00, cell_row(p)};
    c5 = p - ((r5 << 2) + r5);
    return c5[2:0];
  endfunction

  // (x + d) mod 5 for x, d in 0..4
  function automatic rc_t step5(rc_t x, rc_t d);
    logic [3:0] s;
    s = {1'b0, x} + {1'b0, d};
    if (s >= 4'd5) s = s - 4'd5;
    return s[2:0];
  endfunction

  function automatic idx_t cell_at(rc_t r, rc_t c);
    logic [4:0] r5;
    r5 = {2'b00, r};
    return (r5 << 2) + r5 + {2'b00, c};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pcs_ctrl.sv -----
// Controller state machine: decodes commands, sequences the key fill walk and pair steps.
// Depends on pcs_pkg (state, command codes, command/status structs).
`default_nettype none

module pcs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        command,
  input  wire pcs_pkg::pcs_stat_t stat,
  output pcs_pkg::pcs_cmd_t      cmd
);
  import pcs_pkg::*;

  state_t state;
  state_t state_next;
  logic   fire;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    fire       = in_valid && in_ready;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          case (command)
            CMD_KEY_CHAR: begin
              cmd.key_char = 1'b1;
            end
            CMD_KEY_END: begin
              cmd.key_end = 1'b1;
              state_next  = ST_FILL;
            end
            CMD_TEXT_CHAR: begin
              cmd.text_char = 1'b1;
              if (stat.pair_go) state_next = ST_LOOK;
            end
            CMD_TEXT_END: begin
              cmd.text_end = 1'b1;
              if (stat.pair_go) state_next = ST_LOOK;
            end
            CMD_CLEAR_KEY: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_next = ST_IDLE;
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = ST_CELL;
      end
      ST_CELL: begin
        cmd.sq_read = 1'b1;
        state_next  = ST_LOAD;
      end
      ST_LOAD: begin
        // wait until the output register has drained the previous pair
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pcs_datapath.sv -----
// Datapath: key square and position memories, used flags, pairing, lookup stages, output register.
// Depends on pcs_pkg (helper functions, command/status structs).
`default_nettype none

module pcs_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_data,
  input  wire logic [7:0]         character,
  input  wire pcs_pkg::pcs_cmd_t  cmd,
  output pcs_pkg::pcs_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [6:0]              letter,
  output logic                    second_of_pair,
  output logic                    bad_input
);
  import pcs_pkg::*;

  // Storage
  idx_t        key_square [CELLS];
  idx_t        letter_position [26];
  logic [25:0] letter_used;
  idx_t        fill_count;
  idx_t        fill_idx;
  logic        mode;

  // Pairing
  logic [7:0] held_letter;
  logic [7:0] held_letter_next;
  logic       held_valid;
  logic       held_valid_next;
  logic [7:0] pair_a;
  logic [7:0] pair_b;
  logic [7:0] pair_a_next;
  logic [7:0] pair_b_next;
  logic       pair_go;
  idx_t       li;
  logic [7:0] c_up;

  // Pipeline
  idx_t ia;
  idx_t ib;
  idx_t pos_a;
  idx_t pos_b;
  logic bad;
  rc_t  ra, ca, rb, cb, dstep;
  idx_t cell_a;
  idx_t cell_b;
  idx_t sq_a;
  idx_t sq_b;
  logic va;
  logic vb;

  // Output register
  logic [6:0] out_a;
  logic [6:0] out_b;
  logic       out_bad;
  logic       out_second;

  // Placement
  logic place_req;
  idx_t place_idx;
  logic place_ok;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  // Letter placement: one key char, or one step of the key-end walk
  always_comb begin
    li        = letter_idx(character);
    c_up      = CH_A + {3'b000, li};
    place_req = cmd.key_char || (cmd.fill_step && (fill_idx != J_IDX));
    place_idx = cmd.fill_step ? fill_idx : li;
    place_ok  = place_req && (place_idx < NONE_IDX) && !letter_used[place_idx]
                && (fill_count < CELLS);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      letter_used <= '0;
      fill_count  <= '0;
    end else if (place_ok) begin
      letter_used[place_idx] <= 1'b1;
      fill_count             <= fill_count + 5'd1;
    end
  end

  // Square and position memories
  always_ff @(posedge clk) begin
    if (place_ok) begin
      key_square[fill_count]     <= place_idx;
      letter_position[place_idx] <= fill_count;
    end
  end

  // Key-end walk counter
  always_ff @(posedge clk) begin
    if (rst || cmd.key_end) begin
      fill_idx <= '0;
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + 5'd1;
    end
  end

  // Pair formation
  always_comb begin
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    pair_go          = 1'b0;
    pair_a_next      = held_letter;
    pair_b_next      = CH_X;
    if (cmd.text_char) begin
      if (mode) begin
        if (!held_valid) begin
          held_letter_next = character;
          held_valid_next  = 1'b1;
        end else begin
          held_valid_next = 1'b0;
          pair_go         = 1'b1;
          pair_b_next     = character;
        end
      end else if (li != NONE_IDX) begin
        if (!held_valid) begin
          held_letter_next = c_up;
          held_valid_next  = 1'b1;
        end else if (held_letter == c_up) begin
          // doubled letter: pad with X, keep the letter held
          pair_go = 1'b1;
        end else begin
          held_valid_next = 1'b0;
          pair_go         = 1'b1;
          pair_b_next     = c_up;
        end
      end
    end
    if (cmd.text_end && held_valid) begin
      held_valid_next = 1'b0;
      pair_go         = !mode;
    end
    if (cmd.clear) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    held_letter <= held_letter_next;
    if (pair_go) begin
      pair_a <= pair_a_next;
      pair_b <= pair_b_next;
    end
  end

  // Lookup stage: positions of both letters
  assign ia = upper_idx(pair_a);
  assign ib = upper_idx(pair_b);

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      pos_a <= letter_position[ia];
      pos_b <= letter_position[ib];
      bad   <= !(is_upper(pair_a) && letter_used[ia] && is_upper(pair_b) && letter_used[ib]);
    end
  end

  // Cell stage: row/column rule, then square read
  always_comb begin
    ra    = cell_row(pos_a);
    ca    = cell_col(pos_a);
    rb    = cell_row(pos_b);
    cb    = cell_col(pos_b);
    dstep = mode ? STEP_DEC : STEP_ENC;
    if (ra == rb) begin
      cell_a = cell_at(ra, step5(ca, dstep));
      cell_b = cell_at(rb, step5(cb, dstep));
    end else if (ca == cb) begin
      cell_a = cell_at(step5(ra, dstep), ca);
      cell_b = cell_at(step5(rb, dstep), cb);
    end else begin
      cell_a = cell_at(ra, cb);
      cell_b = cell_at(rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_read) begin
      sq_a <= key_square[cell_a];
      sq_b <= key_square[cell_b];
      // cells past the fill count hold no placed letter; they are output as letter A
      va   <= (cell_a < fill_count);
      vb   <= (cell_b < fill_count);
    end
  end

  // Output register: two letters, first then second
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_a   <= (bad || !va) ? CH_A[6:0] : CH_A[6:0] + {2'b00, sq_a};
      out_b   <= (bad || !vb) ? CH_A[6:0] : CH_A[6:0] + {2'b00, sq_b};
      out_bad <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      out_second <= 1'b0;
    end else if (cmd.load) begin
      out_valid  <= 1'b1;
      out_second <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_second) begin
        out_valid <= 1'b0;
      end else begin
        out_second <= 1'b1;
      end
    end
  end

  assign letter         = out_second ? out_b : out_a;
  assign second_of_pair = out_second;
  assign bad_input      = out_bad;

  // Status to controller
  assign stat.pair_go   = pair_go;
  assign stat.fill_last = (fill_idx == LAST_IDX);
  assign stat.out_busy  = out_valid;

endmodule

`default_nettype wire

// ----- rtl/playfair_cipher_stream.sv -----
// Top level of the Playfair stream cipher: controller plus datapath.
// Depends on pcs_pkg, pcs_ctrl and pcs_datapath.
//
//  Channel | Signals                                         | Handshake
//  --------+-------------------------------------------------+-----------------
//  input   | command[2:0], character[7:0]                    | in_valid/in_ready
//  output  | letter[6:0], second_of_pair, bad_input          | out_valid/out_ready
//  config  | cfg_data (mode)                                 | cfg_write
//
// Key char, clear key, unknown commands and text chars that close no pair leave the controller idle.
// A pair steps through accept, position read, square read and output load; the two
// letters then leave while the next items are accepted.
// Key end walks one step per letter A..Z through the single write port.
// A pair waits in its load step while the output register still holds the previous pair.
// Synchronous reset clears mode, flags, fill count and handshakes; no clearing pass.
`default_nettype none

module playfair_cipher_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire logic [7:0] character,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      letter,
  output logic            second_of_pair,
  output logic            bad_input
);
  import pcs_pkg::*;

  pcs_cmd_t  cmd;
  pcs_stat_t stat;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .character      (character),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .letter         (letter),
    .second_of_pair (second_of_pair),
    .bad_input      (bad_input)
  );

`ifndef SYNTHESIS
  // After the first letter of a pair leaves, the second follows with the same flag
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !second_of_pair |=> out_valid && second_of_pair
      && $stable(bad_input))
    else $error("second letter of pair missing");

  // Output letters are always uppercase
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (letter >= CH_A[6:0]) && (letter <= CH_Z[6:0]))
    else $error("output letter out of range");

  // A new pair is loaded only into an empty output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !out_valid)
    else $error("pair loaded over pending output");

  // No input is taken while a pair is in the lookup pipeline or the key-end walk runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.look || cmd.sq_read || cmd.fill_step) |-> !in_ready)
    else $error("input accepted while busy");
`endif

endmodule

`default_nettype wire

// ----- test/playfair_stream_checker.sv -----
// Checker for the Playfair stream block: watches the input, output and mode write ports,
// predicts every output letter from its own copy of the key square, and counts mismatches.
// Depends on pcs_pkg for the command codes and ASCII constants.
module playfair_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] command,
  input  logic [7:0] character,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] letter,
  input  logic       second_of_pair,
  input  logic       bad_input,
  output int         mismatches,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  typedef struct packed {
    logic [6:0] letter;
    logic       second_of_pair;
    logic       bad_input;
  } pair_letter_t;

  // Predicted key square and text state
  logic [4:0]   square_letter [25];
  logic [4:0]   letter_cell [26];
  logic         letter_placed [26];
  int           filled;
  logic [7:0]   held_byte;
  logic         held;
  logic         decrypt;
  pair_letter_t cipher_q [$];

  // Letter number 0..25 of either case, J folded onto I; 26 for a non-letter
  function automatic int letter_number(logic [7:0] ch);
    int n;
    if (ch >= CH_A && ch <= CH_Z) n = ch - CH_A;
    else if (ch >= CH_LA && ch <= CH_LZ) n = ch - CH_LA;
    else return 26;
    return (n == J_IDX) ? I_IDX : n;
  endfunction

  function automatic void clear_square();
    for (int k = 0; k < 26; k++) begin
      letter_cell[k] = '0;
      letter_placed[k] = 1'b0;
      if (k < 25) square_letter[k] = '0;
    end
    filled = 0;
    held_byte = '0;
    held = 1'b0;
  endfunction

  function automatic void place_in_square(int n);
    if (n >= 26 || letter_placed[n] || filled >= 25) return;
    square_letter[filled] = n[4:0];
    letter_cell[n] = filled[4:0];
    letter_placed[n] = 1'b1;
    filled++;
  endfunction

  // Cell of an uppercase byte (J read as I), 25 on a miss
  function automatic int cell_of_byte(logic [7:0] ch);
    int n;
    if (ch < CH_A || ch > CH_Z) return 25;
    n = ch - CH_A;
    if (n == J_IDX) n = I_IDX;
    if (!letter_placed[n]) return 25;
    return letter_cell[n];
  endfunction

  function automatic logic [6:0] letter_at(int row, int col);
    logic [7:0] ch;
    ch = {3'b000, square_letter[(row % 5) * 5 + (col % 5)]} + CH_A;
    return ch[6:0];
  endfunction

  // Queue the two letters of one enciphered or deciphered pair
  function automatic void cipher_pair(logic [7:0] a, logic [7:0] b);
    int pa, pb, ra, ca, rb, cb, d;
    pair_letter_t lead, trail;
    pa = cell_of_byte(a);
    pb = cell_of_byte(b);
    lead.second_of_pair = 1'b0;
    trail.second_of_pair = 1'b1;
    if (pa > 24 || pb > 24) begin
      lead.letter = CH_A[6:0];
      trail.letter = CH_A[6:0];
      lead.bad_input = 1'b1;
      trail.bad_input = 1'b1;
    end else begin
      ra = pa / 5;
      ca = pa % 5;
      rb = pb / 5;
      cb = pb % 5;
      d = decrypt ? 4 : 1;
      lead.bad_input = 1'b0;
      trail.bad_input = 1'b0;
      if (ra == rb) begin
        lead.letter = letter_at(ra, ca + d);
        trail.letter = letter_at(rb, cb + d);
      end else if (ca == cb) begin
        lead.letter = letter_at(ra + d, ca);
        trail.letter = letter_at(rb + d, cb);
      end else begin
        lead.letter = letter_at(ra, cb);
        trail.letter = letter_at(rb, ca);
      end
    end
    cipher_q.push_back(lead);
    cipher_q.push_back(trail);
  endfunction

  function automatic void predict_item(logic [2:0] cmd, logic [7:0] ch);
    int n;
    logic [7:0] up;
    case (cmd)
      CMD_KEY_CHAR: place_in_square(letter_number(ch));
      CMD_KEY_END: begin
        for (int k = 0; k < 26; k++)
          if (k != J_IDX) place_in_square(k);
      end
      CMD_CLEAR_KEY: clear_square();
      CMD_TEXT_CHAR: begin
        if (decrypt) begin
          // raw bytes paired as they come
          if (!held) begin
            held_byte = ch;
            held = 1'b1;
          end else begin
            held = 1'b0;
            cipher_pair(held_byte, ch);
          end
        end else begin
          n = letter_number(ch);
          if (n < 26) begin
            up = CH_A + n[7:0];
            if (!held) begin
              held_byte = up;
              held = 1'b1;
            end else if (held_byte == up) begin
              // doubled letter: pad with X, keep the new one open
              cipher_pair(held_byte, CH_X);
            end else begin
              held = 1'b0;
              cipher_pair(held_byte, up);
            end
          end
        end
      end
      CMD_TEXT_END: begin
        if (held) begin
          held = 1'b0;
          if (!decrypt) cipher_pair(held_byte, CH_X);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(string what, pair_letter_t want, pair_letter_t got);
    if (mismatches < 10)
      $display("%0t: %s: expected letter %0d second %0d bad %0d, got letter %0d second %0d bad %0d",
               $time, what, want.letter, want.second_of_pair, want.bad_input,
               got.letter, got.second_of_pair, got.bad_input);
    mismatches++;
  endfunction

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin : monitor
    pair_letter_t want, got;
    if (rst) begin
      clear_square();
      decrypt = 1'b0;
      cipher_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) decrypt = cfg_data;
      if (in_valid && in_ready) predict_item(command, character);
      if (out_valid && out_ready) begin
        got.letter = letter;
        got.second_of_pair = second_of_pair;
        got.bad_input = bad_input;
        if (cipher_q.size() == 0) begin
          want = '0;
          flag_mismatch("letter with none expected", want, got);
        end else begin
          want = cipher_q.pop_front();
          if (got != want) flag_mismatch("letter mismatch", want, got);
        end
      end
    end
    pending = cipher_q.size();
  end

endmodule

// ----- test/tb_playfair_cipher_stream.sv -----
// Testbench top for playfair_cipher_stream: clock, reset, key and text stimulus, mode writes
// and the final verdict. Depends on pcs_pkg and playfair_stream_checker.
module tb_playfair_cipher_stream;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] command;
  logic [7:0] character;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] letter;
  logic       second_of_pair;
  logic       bad_input;
  int         mismatches;
  int         pending;

  // Idle rates in percent, receiver hold-off in cycles
  int   send_idle = 13;
  int   recv_idle = 75;
  int   hold_off = 0;
  int   text_sent = 0;
  logic cur_mode = 1'b0;

  playfair_cipher_stream i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .character      (character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .letter         (letter),
    .second_of_pair (second_of_pair),
    .bad_input      (bad_input)
  );

  playfair_stream_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .character      (character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .letter         (letter),
    .second_of_pair (second_of_pair),
    .bad_input      (bad_input),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("playfair_cipher_stream: mismatch");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    character = ch;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending, wait for every pending letter, then let a key-end walk finish
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = m;
    @(negedge clk);
    cfg_write = 1'b0;
    cur_mode = m;
  endtask

  function automatic logic [7:0] pick_letter(input bit lower);
    return (lower ? CH_LA : CH_A) + 8'($urandom_range(25));
  endfunction

  // A key (often fresh), then a run of text, mostly well formed
  task automatic run_session(input int idx);
    int k;
    int n_text;
    logic [7:0] ch;
    logic [7:0] prev;
    if (idx == 0 || $urandom_range(2) == 0) begin
      send_item(CMD_CLEAR_KEY, 8'($urandom_range(255)));
      repeat ($urandom_range(12)) begin
        if ($urandom_range(9) < 8) ch = pick_letter($urandom_range(1));
        else ch = 8'($urandom_range(255));
        send_item(CMD_KEY_CHAR, ch);
      end
      // now and then the square stays incomplete
      if ($urandom_range(7) != 0) send_item(CMD_KEY_END, 8'($urandom_range(255)));
    end
    n_text = $urandom_range(8, 30);
    if (idx == 1) begin
      n_text = 30;
      hold_off = 300;
    end
    prev = CH_A;
    repeat (n_text) begin
      k = $urandom_range(99);
      if (k < 5) begin
        send_item(3'($urandom_range(7)), 8'($urandom_range(255)));
      end else begin
        if (k < 15) ch = 8'($urandom_range(255));
        else if (k < 30 && !cur_mode) ch = prev ^ {2'b00, 1'($urandom_range(1)), 5'b0};
        else ch = pick_letter(!cur_mode && $urandom_range(1));
        if ((ch >= CH_A && ch <= CH_Z) || (ch >= CH_LA && ch <= CH_LZ)) prev = ch;
        send_item(CMD_TEXT_CHAR, ch);
        text_sent++;
      end
    end
    if ($urandom_range(9) != 0) send_item(CMD_TEXT_END, 8'($urandom_range(255)));
    wait_idle();
    if ($urandom_range(2) == 0) write_mode($urandom_range(1));
  endtask

  initial begin
    int session;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_KEY_CHAR;
    character = '0;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Pair on an empty square: both letters flagged
    send_item(CMD_TEXT_CHAR, "A");
    send_item(CMD_TEXT_CHAR, "b");
    // Key with lowercase j, a non-letter, a repeat and byte 255
    send_item(CMD_KEY_CHAR, "P");
    send_item(CMD_KEY_CHAR, "j");
    send_item(CMD_KEY_CHAR, "!");
    send_item(CMD_KEY_CHAR, "P");
    send_item(CMD_KEY_CHAR, 8'hFF);
    send_item(CMD_KEY_END, 8'h00);
    // repeated key end and a key char into a full square do nothing
    send_item(CMD_KEY_END, 8'h00);
    send_item(CMD_KEY_CHAR, "Z");
    // Encrypt: non-letter dropped, doubled letter padded, J read as I
    send_item(CMD_TEXT_CHAR, "h");
    send_item(CMD_TEXT_CHAR, "e");
    send_item(CMD_TEXT_CHAR, 8'h00);
    send_item(CMD_TEXT_CHAR, "l");
    send_item(CMD_TEXT_CHAR, "l");
    send_item(CMD_TEXT_CHAR, "J");
    send_item(CMD_TEXT_END, 8'h00);
    wait_idle();
    write_mode(1'b1);
    // Decrypt: lowercase misses, J looks up as I, lone trailing byte dropped
    send_item(CMD_TEXT_CHAR, "a");
    send_item(CMD_TEXT_CHAR, "Q");
    send_item(CMD_TEXT_CHAR, "J");
    send_item(CMD_TEXT_CHAR, "Z");
    send_item(CMD_TEXT_CHAR, "K");
    send_item(CMD_TEXT_END, 8'h00);
    // Held byte carried across a mode change, then padded at text end
    send_item(CMD_TEXT_CHAR, "M");
    wait_idle();
    write_mode(1'b0);
    send_item(CMD_TEXT_CHAR, "m");
    send_item(CMD_TEXT_END, 8'h00);
    // Clear key drops an open letter
    send_item(CMD_TEXT_CHAR, "Q");
    send_item(CMD_CLEAR_KEY, 8'h00);
    wait_idle();

    // Random sessions over three idle profiles
    session = 0;
    while (text_sent < 300) begin
      if (text_sent < 100) begin
        send_idle = 13;
        recv_idle = 75;
      end else if (text_sent < 200) begin
        send_idle = 75;
        recv_idle = 13;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_session(session);
      session++;
    end
    wait_idle();

    if (mismatches == 0 && pending == 0) begin
      $display("playfair_cipher_stream: match");
    end else begin
      $display("playfair_cipher_stream: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcs_pkg.sv
rtl/pcs_ctrl.sv
rtl/pcs_datapath.sv
rtl/playfair_cipher_stream.sv
test/playfair_stream_checker.sv
test/tb_playfair_cipher_stream.sv
